@@ design/hcjd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcjd_pkg
// Shared constants, codes and controller/datapath bundles for the Hinkley
// cumulative-sum jump detector.
// ----------------------------------------------------------------------------
package hcjd_pkg;

    // default structural sizes
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF    = 48;
    localparam int COUNT_WIDTH_DEF  = 16;

    // fixed register and field widths
    localparam int THR_WIDTH       = 31;
    localparam int MODE_WIDTH      = 2;
    localparam int JUMP_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_JUMP = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEST_MODE = 2'd2;

    // register reset values
    localparam logic [THR_WIDTH-1:0]  THRESHOLD_RST = 31'd13107;
    localparam logic [THR_WIDTH-1:0]  HALF_JUMP_RST = 31'd6554;
    localparam logic [MODE_WIDTH-1:0] TEST_MODE_RST = 2'd2;

    // test modes; any other code tests both directions
    localparam logic [MODE_WIDTH-1:0] MODE_DOWN = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_UP   = 2'd1;

    // jump codes
    localparam logic [JUMP_WIDTH-1:0] JUMP_NONE = 2'd0;
    localparam logic [JUMP_WIDTH-1:0] JUMP_DOWN = 2'd1;
    localparam logic [JUMP_WIDTH-1:0] JUMP_UP   = 2'd2;

    typedef struct packed {
        logic [THR_WIDTH-1:0]  threshold;
        logic [THR_WIDTH-1:0]  half_jump;
        logic [MODE_WIDTH-1:0] test_mode;
    } hcjd_cfg_t;

    typedef struct packed {
        logic load;      // capture the input sample
        logic sum;       // count, mean seed, cumulative sums
        logic test;      // max/min, statistics, jump, divider setup
        logic div_step;  // one quotient bit
        logic div_last;  // final quotient bit, commit the mean
        logic publish;   // move result into the output register
    } hcjd_cmd_t;

    typedef struct packed {
        logic div_needed;
    } hcjd_status_t;

endpackage

@@ design/hinkley_cusum_jump_detector_top.sv @@
// ----------------------------------------------------------------------------
// hinkley_cusum_jump_detector_top
// Page-Hinkley CUSUM jump detector on signed fixed-point samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_valid/in_ready channel, one result (jump code and
//   both statistics, taken before any clearing) leaves on out_valid/out_ready
//   for every sample. Registers are written on the cfg channel (index 0
//   threshold, 1 half jump, 2 test mode); cfg_ready is always high, and
//   writes belong in idle periods only.
//   After the input transfer a sample passes the sum and test steps, then the
//   serial mean division when the running mean is updated, then waits to be
//   published. A new sample is taken only once the previous one is published;
//   the restoring divider that computes (sample - mean) / count resolves one
//   quotient bit per cycle.
//   The finished result sits in an output register; a new sample is taken
//   while it waits, and a stalled receiver only holds the next result back
//   in its last step. Reset clears count, mean and sums, loads the default
//   registers (0.2, 0.1, both directions) and empties the output register.
// ----------------------------------------------------------------------------
module hinkley_cusum_jump_detector_top #(
    parameter int SAMPLE_WIDTH = hcjd_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = hcjd_pkg::ACC_WIDTH_DEF,
    parameter int COUNT_WIDTH  = hcjd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hcjd_pkg::JUMP_WIDTH-1:0]      jump,
    output logic [ACC_WIDTH-2:0]                 down_statistic,
    output logic [ACC_WIDTH-2:0]                 up_statistic,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hcjd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hcjd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import hcjd_pkg::*;

    hcjd_cfg_t    cfg;
    hcjd_cmd_t    cmd;
    hcjd_status_t status;

    assign cfg_ready = 1'b1;

    hcjd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hcjd_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hcjd_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .sample         (sample),
        .jump           (jump),
        .down_statistic (down_statistic),
        .up_statistic   (up_statistic)
    );

endmodule

@@ design/hcjd_cfg.sv @@
// ----------------------------------------------------------------------------
// hcjd_cfg
// Configuration register file: threshold, half jump and test mode.
// ----------------------------------------------------------------------------
module hcjd_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [hcjd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [hcjd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output hcjd_pkg::hcjd_cfg_t                  cfg
);
    import hcjd_pkg::*;

    hcjd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.half_jump <= HALF_JUMP_RST;
            cfg_reg.test_mode <= TEST_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[THR_WIDTH-1:0];
                CFG_HALF_JUMP: cfg_reg.half_jump <= cfg_data[THR_WIDTH-1:0];
                CFG_TEST_MODE: cfg_reg.test_mode <= cfg_data[MODE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/hcjd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcjd_ctrl
// Sequencer: accept, sum update, test, serial mean division, result hand-off.
// ----------------------------------------------------------------------------
module hcjd_ctrl #(
    parameter int SAMPLE_WIDTH = hcjd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  hcjd_pkg::hcjd_status_t status,
    output hcjd_pkg::hcjd_cmd_t    cmd
);
    import hcjd_pkg::*;

    // one quotient bit per dividend bit
    localparam int DIV_STEPS = SAMPLE_WIDTH + 1;
    localparam int DCW       = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_TEST = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } hcjd_state_t;

    hcjd_state_t    state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic           div_last;
    logic           can_publish;

    assign div_last    = (div_cnt_reg == DCW'(DIV_STEPS - 1));
    assign can_publish = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test     = 1'b1;
                div_cnt_next = '0;
                state_next   = status.div_needed ? ST_DIV : ST_HOLD;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = div_last;
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_last)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (can_publish)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/hcjd_dp.sv @@
// ----------------------------------------------------------------------------
// hcjd_dp
// Datapath: count, running mean, saturating cumulative sums with max/min,
// statistics, jump decision, restoring divider and output register.
// ----------------------------------------------------------------------------
module hcjd_dp #(
    parameter int SAMPLE_WIDTH = hcjd_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = hcjd_pkg::ACC_WIDTH_DEF,
    parameter int COUNT_WIDTH  = hcjd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hcjd_pkg::hcjd_cmd_t                cmd,
    output hcjd_pkg::hcjd_status_t             status,
    input  hcjd_pkg::hcjd_cfg_t                cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic [hcjd_pkg::JUMP_WIDTH-1:0]    jump,
    output logic [ACC_WIDTH-2:0]               down_statistic,
    output logic [ACC_WIDTH-2:0]               up_statistic
);
    import hcjd_pkg::*;

    localparam int S  = SAMPLE_WIDTH;
    localparam int A  = ACC_WIDTH;
    localparam int C  = COUNT_WIDTH;
    localparam int N  = S + 1;                              // dividend bits
    localparam int DW = ((S > THR_WIDTH) ? S : THR_WIDTH) + 2;  // per-sample increment
    localparam int WW = ((A > DW) ? A : DW) + 1;            // pre-saturation sum
    localparam int TW = ((A - 1) > THR_WIDTH) ? (A - 1) : THR_WIDTH;

    localparam logic [WW-1:0] ACC_MAX_W = WW'({(A-1){1'b1}});
    localparam logic [WW-1:0] ACC_MIN_W = ~ACC_MAX_W;

    function automatic logic [A-1:0] sat_acc(input logic [WW-1:0] w);
        logic [A-1:0] r;
        if ($signed(w) > $signed(ACC_MAX_W))
            r = ACC_MAX_W[A-1:0];
        else if ($signed(w) < $signed(ACC_MIN_W))
            r = ACC_MIN_W[A-1:0];
        else
            r = w[A-1:0];
        return r;
    endfunction

    // state
    logic [S-1:0] sample_reg;
    logic [C-1:0] count_reg;
    logic [S-1:0] mean_reg;
    logic [A-1:0] dsum_reg, dmax_reg, usum_reg, umin_reg;

    // pending result and output register
    logic [JUMP_WIDTH-1:0] res_jump_reg, out_jump_reg;
    logic [A-2:0]          res_dstat_reg, res_ustat_reg;
    logic [A-2:0]          out_dstat_reg, out_ustat_reg;

    // divider
    logic [N-1:0] quo_reg;
    logic [C-1:0] rem_reg;
    logic [C-1:0] divisor_reg;
    logic         neg_reg;

    logic do_down, do_up, both;

    // sum stage
    logic [C-1:0]  count_inc;
    logic [S-1:0]  mean_eff;
    logic [DW-1:0] inc_base, inc_down, inc_up;
    logic [WW-1:0] dsum_wide, usum_wide;

    // test stage
    logic [A:0]            ddiff, udiff;
    logic                  dpos, upos;
    logic [A-2:0]          dstat, ustat;
    logic [A-1:0]          dmax_new, umin_new;
    logic                  dgt, ugt;
    logic [JUMP_WIDTH-1:0] jump_code;
    logic [N-1:0]          div_diff, div_mag;

    // divide step
    logic [C:0]   trial, trial_sub;
    logic         q_bit;
    logic [N-1:0] quo_next, q_signed, mean_sum;

    assign do_down = (cfg.test_mode != MODE_UP);
    assign do_up   = (cfg.test_mode != MODE_DOWN);
    assign both    = do_down && do_up;

    // ---- sum stage ----
    assign count_inc = (count_reg == {C{1'b1}}) ? count_reg : count_reg + C'(1);
    assign mean_eff  = (count_inc == C'(1)) ? sample_reg : mean_reg;
    assign inc_base  = DW'($signed(sample_reg)) - DW'($signed(mean_eff));
    assign inc_down  = inc_base + DW'(cfg.half_jump);
    assign inc_up    = inc_base - DW'(cfg.half_jump);
    assign dsum_wide = WW'($signed(dsum_reg)) + WW'($signed(inc_down));
    assign usum_wide = WW'($signed(usum_reg)) + WW'($signed(inc_up));

    // ---- test stage ----
    // max >= sum holds before each update, so one difference gives the
    // statistic, the new extreme and the equality test.
    assign ddiff = (A+1)'($signed(dmax_reg)) - (A+1)'($signed(dsum_reg));
    assign udiff = (A+1)'($signed(usum_reg)) - (A+1)'($signed(umin_reg));
    assign dpos  = !ddiff[A] && (ddiff != '0);
    assign upos  = !udiff[A] && (udiff != '0);

    assign dstat = !dpos ? '0 : (ddiff[A-1] ? {(A-1){1'b1}} : ddiff[A-2:0]);
    assign ustat = !upos ? '0 : (udiff[A-1] ? {(A-1){1'b1}} : udiff[A-2:0]);

    assign dmax_new = ddiff[A] ? dsum_reg : dmax_reg;
    assign umin_new = udiff[A] ? usum_reg : umin_reg;

    assign dgt = TW'(dstat) > TW'(cfg.threshold);
    assign ugt = TW'(ustat) > TW'(cfg.threshold);

    always_comb
    begin
        if (do_down && dgt)
            jump_code = JUMP_DOWN;
        else if (do_up && ugt)
            jump_code = JUMP_UP;
        else
            jump_code = JUMP_NONE;
    end

    // a jump needs a nonzero statistic, so it never coincides with a mean update
    assign status.div_needed = !dpos && !upos && (count_reg != '0);

    assign div_diff = N'($signed(sample_reg)) - N'($signed(mean_reg));
    assign div_mag  = div_diff[N-1] ? (~div_diff + N'(1)) : div_diff;

    // ---- restoring divide step ----
    assign trial     = {rem_reg, quo_reg[N-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign q_bit     = !trial_sub[C];
    assign quo_next  = {quo_reg[N-2:0], q_bit};
    assign q_signed  = neg_reg ? (~quo_next + N'(1)) : quo_next;
    assign mean_sum  = N'($signed(mean_reg)) + q_signed;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= sample;
        if (cmd.test)
        begin
            res_jump_reg  <= jump_code;
            res_dstat_reg <= dstat;
            res_ustat_reg <= ustat;
            quo_reg       <= div_mag;
            rem_reg       <= '0;
            divisor_reg   <= count_reg;
            neg_reg       <= div_diff[N-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= q_bit ? trial_sub[C-1:0] : trial[C-1:0];
        end
        if (cmd.publish)
        begin
            out_jump_reg  <= res_jump_reg;
            out_dstat_reg <= res_dstat_reg;
            out_ustat_reg <= res_ustat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            dsum_reg  <= '0;
            dmax_reg  <= '0;
            usum_reg  <= '0;
            umin_reg  <= '0;
        end
        else if (cmd.sum)
        begin
            count_reg <= count_inc;
            mean_reg  <= mean_eff;
            if (do_down)
                dsum_reg <= sat_acc(dsum_wide);
            if (do_up)
                usum_reg <= sat_acc(usum_wide);
        end
        else if (cmd.test)
        begin
            if (jump_code == JUMP_NONE)
            begin
                dmax_reg <= dmax_new;
                umin_reg <= umin_new;
            end
            else
            begin
                count_reg <= '0;
                if (both)
                begin
                    dsum_reg <= '0;
                    dmax_reg <= '0;
                    usum_reg <= '0;
                    umin_reg <= '0;
                    mean_reg <= sample_reg;
                end
                else if (jump_code == JUMP_DOWN)
                begin
                    dsum_reg <= '0;
                    dmax_reg <= '0;
                    umin_reg <= umin_new;
                end
                else
                begin
                    usum_reg <= '0;
                    umin_reg <= '0;
                    dmax_reg <= dmax_new;
                end
            end
        end
        else if (cmd.div_last)
        begin
            mean_reg <= mean_sum[S-1:0];
        end
    end

    assign jump           = out_jump_reg;
    assign down_statistic = out_dstat_reg;
    assign up_statistic   = out_ustat_reg;

endmodule

@@ tb/sv/hinkley_cusum_jump_detector_top_test.sv @@
// ----------------------------------------------------------------------------
// hinkley_cusum_jump_detector_top_test
// Self-checking bench for the Hinkley CUSUM jump detector. Samples go in on
// a valid/ready channel with random gaps, results are checked one by one
// against an in-bench model of count, mean and both cumulative sums. Runs
// cover register defaults, every test mode, a held statistic followed by a
// late mean update, a long output stall and random level/step sequences
// under changing registers.
// ----------------------------------------------------------------------------
module hinkley_cusum_jump_detector_top_test;

    import hcjd_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int AW = ACC_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;

    localparam longint SUM_HI = (64'sd1 <<< (AW - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam logic [CW-1:0] COUNT_TOP = '1;

    localparam logic [MODE_WIDTH-1:0] MODE_BOTH  = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;  // decodes as both

    localparam int QUIET_LIMIT   = 2000;
    localparam int RX_HOLD_LEN   = 300;
    localparam int PHASE_ITEMS   = 90;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_ITEMS    = 40;

    typedef struct packed {
        logic [JUMP_WIDTH-1:0] jump;
        logic [AW-2:0]         down_stat;
        logic [AW-2:0]         up_stat;
    } verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SW-1:0]       sample;
    logic                       out_valid;
    logic                       out_ready;
    logic [JUMP_WIDTH-1:0]      jump;
    logic [AW-2:0]              down_statistic;
    logic [AW-2:0]              up_statistic;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // detector model state
    logic [THR_WIDTH-1:0]  alpha;
    logic [THR_WIDTH-1:0]  half_delta;
    logic [MODE_WIDTH-1:0] mode_sel;
    logic [CW-1:0]         n_seen;
    longint                mean_est;
    longint                down_sum;
    longint                down_peak;
    longint                up_sum;
    longint                up_floor;

    verdict_t pending_verdicts[$];
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    int       hold_request = 0;
    bit       steady       = 1'b0;

    hinkley_cusum_jump_detector_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .jump           (jump),
        .down_statistic (down_statistic),
        .up_statistic   (up_statistic),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic longint clamp_acc(input longint acc, input longint step);
        longint t;
        t = acc + step;
        if (t > SUM_HI)
            return SUM_HI;
        if (t < SUM_LO)
            return SUM_LO;
        return t;
    endfunction

    // hi - lo, floored at zero and clipped to the output field
    function automatic logic [AW-2:0] spread(input longint hi, input longint lo);
        longint d;
        if (hi <= lo)
            return '0;
        d = hi - lo;
        if (d > SUM_HI)
            d = SUM_HI;
        return d[AW-2:0];
    endfunction

    function automatic verdict_t cusum_predict(input logic [SW-1:0] raw);
        longint   s;
        longint   hj;
        longint   divisor;
        logic     look_down;
        logic     look_up;
        verdict_t v;
        s         = longint'(signed'(raw));
        hj        = half_delta;
        look_down = (mode_sel != MODE_UP);
        look_up   = (mode_sel != MODE_DOWN);

        if (n_seen != COUNT_TOP)
            n_seen++;
        if (n_seen == 1)
            mean_est = s;

        if (look_down)
        begin
            down_sum = clamp_acc(down_sum, s - mean_est + hj);
            if (down_sum > down_peak)
                down_peak = down_sum;
        end
        if (look_up)
        begin
            up_sum = clamp_acc(up_sum, s - mean_est - hj);
            if (up_sum < up_floor)
                up_floor = up_sum;
        end

        v.down_stat = spread(down_peak, down_sum);
        v.up_stat   = spread(up_sum, up_floor);
        v.jump      = JUMP_NONE;
        if (look_down && v.down_stat > alpha)
            v.jump = JUMP_DOWN;
        else if (look_up && v.up_stat > alpha)
            v.jump = JUMP_UP;

        // mean only moves while neither statistic has started to build
        divisor = n_seen;
        if (down_peak == down_sum && up_sum == up_floor && n_seen != 0)
            mean_est += (s - mean_est) / divisor;

        if (v.jump != JUMP_NONE)
        begin
            if (look_down && look_up)
            begin
                down_sum  = 0;
                down_peak = 0;
                up_sum    = 0;
                up_floor  = 0;
                mean_est  = s;
            end
            else if (v.jump == JUMP_DOWN)
            begin
                down_sum  = 0;
                down_peak = 0;
            end
            else
            begin
                up_sum   = 0;
                up_floor = 0;
            end
            n_seen = '0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // valid stays up across back-to-back transfers; lowered only for a gap
    task automatic send_sample(input logic [SW-1:0] s);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pending_verdicts.push_back(cusum_predict(s));
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: alpha      = data[THR_WIDTH-1:0];
            CFG_HALF_JUMP: half_delta = data[THR_WIDTH-1:0];
            CFG_TEST_MODE: mode_sel   = data[MODE_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every result, then let the divider path drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SW + 8) @(posedge clk);
    endtask

    function automatic logic [THR_WIDTH-1:0] pick_reg31();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return THR_WIDTH'($urandom_range(0, 32'h0002_0000));
            3: return THR_WIDTH'($urandom_range(0, 32'h0020_0000));
            default: return THR_WIDTH'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // register defaults, sample extremes and alternating bit patterns
    task automatic test_directed_edges();
        logic [SW-1:0] seq [10];
        seq = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                32'h5555_5555, 32'hAAAA_AAAA};
        for (int i = 0; i < 10; i++)
            send_sample(seq[i]);
    endtask

    // each mode, code three included; untested sums must hold their value
    task automatic test_each_mode();
        logic [MODE_WIDTH-1:0] modes [4];
        logic [SW-1:0]         steps [4];
        modes = '{MODE_DOWN, MODE_UP, MODE_BOTH, MODE_SPARE};
        steps = '{32'h0001_0000, 32'h0004_0000, 32'hFFFC_0000, 32'hFFFC_0000};
        settle();
        write_cfg(CFG_THRESHOLD, 32'h0000_8000);
        write_cfg(CFG_HALF_JUMP, 32'h0000_1000);
        for (int m = 0; m < 4; m++)
        begin
            settle();
            write_cfg(CFG_TEST_MODE, {30'd0, modes[m]});
            for (int i = 0; i < 4; i++)
                send_sample(steps[i]);
        end
    endtask

    // Holds the downward sum one below its peak so the mean never updates
    // (short item time) while the upward sum keeps falling by large steps.
    // One sample then closes the downward gap so the mean divides by a large count.
    task automatic test_held_statistic();
        bit flip;
        settle();
        write_cfg(CFG_THRESHOLD, 32'h0000_0000);
        write_cfg(CFG_HALF_JUMP, 32'h0000_0000);
        write_cfg(CFG_TEST_MODE, {30'd0, MODE_BOTH});
        // zero threshold: swing until a jump leaves everything cleared
        flip = 1'b0;
        do
        begin
            send_sample(flip ? 32'h8000_0000 : 32'h7FFF_FFFF);
            flip = !flip;
        end
        while (n_seen != 0);
        settle();
        write_cfg(CFG_THRESHOLD, 32'hFFFF_FFFF);
        write_cfg(CFG_HALF_JUMP, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);   // seeds the mean
        send_sample(32'hFFFF_FFFF);   // down sum drops one below its peak
        for (int k = 0; k < HOLD_ITEMS; k++)
        begin
            steady = (k < HOLD_ITEMS - 10);
            send_sample(32'h0000_0000);
        end
        steady = 1'b0;
        send_sample(32'h0000_0001);   // mean update after the long hold
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
    endtask

    // receiver stalls for a long stretch while samples keep coming
    task automatic test_backpressure();
        steady       = 1'b1;
        hold_request = RX_HOLD_LEN;
        for (int i = 0; i < 12; i++)
            send_sample($urandom());
        steady = 1'b0;
    endtask

    // level segments with noise, steps between them and stray samples
    task automatic test_random_phases();
        int            n;
        int            seg_len;
        int            lvl;
        int            amp;
        logic [SW-1:0] s;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            write_cfg(CFG_THRESHOLD, {1'($urandom()), pick_reg31()});
            write_cfg(CFG_HALF_JUMP, {1'($urandom()), pick_reg31()});
            write_cfg(CFG_TEST_MODE, $urandom());
            steady = (phase == 3);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                seg_len = $urandom_range(3, 25);
                case ($urandom_range(0, 9))
                    0: lvl = 32'h7FFF_0000;
                    1: lvl = 32'h8001_0000;
                    default: lvl = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                endcase
                case ($urandom_range(0, 3))
                    0: amp = 0;
                    1: amp = 32'h200;
                    2: amp = 32'h8000;
                    default: amp = 32'h8_0000;
                endcase
                for (int k = 0; k < seg_len && n < PHASE_ITEMS; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        s = $urandom();
                    else
                        s = lvl + $urandom_range(0, 2 * amp) - amp;
                    send_sample(s);
                    n++;
                end
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && !steady && $urandom_range(0, 7) == 0)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result transfer with no sample pending");
            else
            begin
                want = pending_verdicts.pop_front();
                if (jump !== want.jump)
                    report_mismatch($sformatf("jump got %0d want %0d", jump, want.jump));
                if (down_statistic !== want.down_stat)
                    report_mismatch($sformatf("down_statistic got %0h want %0h",
                                              down_statistic, want.down_stat));
                if (up_statistic !== want.up_stat)
                    report_mismatch($sformatf("up_statistic got %0h want %0h",
                                              up_statistic, want.up_stat));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_THRESHOLD;
        cfg_data   = '0;
        alpha      = THRESHOLD_RST;
        half_delta = HALF_JUMP_RST;
        mode_sel   = TEST_MODE_RST;
        n_seen     = '0;
        mean_est   = 0;
        down_sum   = 0;
        down_peak  = 0;
        up_sum     = 0;
        up_floor   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_each_mode();
        test_held_statistic();
        test_backpressure();
        test_random_phases();
        settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
design/hcjd_pkg.sv
design/hcjd_cfg.sv
design/hcjd_ctrl.sv
design/hcjd_dp.sv
design/hinkley_cusum_jump_detector_top.sv
tb/sv/hinkley_cusum_jump_detector_top_test.sv
